// ----- rtl/core/csvtok_pkg.sv -----
// shared types and constants of the csv field tokenizer
`timescale 1ns / 1ps

package csvtok_pkg;

  localparam int unsigned LineBitsDefault   = 32;
  localparam int unsigned ColumnBitsDefault = 16;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LineOutW = 32;
  localparam int unsigned ColOutW  = 16;
  localparam int unsigned TdataW   = 56;
  localparam int unsigned TuserW   = 3;

  localparam logic [ByteW-1:0] QuoteByte    = 8'h22;
  localparam logic [ByteW-1:0] NewlineByte  = 8'h0A;
  localparam logic [ByteW-1:0] DelimDefault = 8'h2C;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    MODE_START      = 4'b0001,
    MODE_PLAIN      = 4'b0010,
    MODE_QUOTED     = 4'b0100,
    MODE_QUOTE_SEEN = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e               kind;
    logic [ByteW-1:0]    data_byte;
    logic                stray_error;
    logic [LineOutW-1:0] line_number;
    logic [ColOutW-1:0]  column_number;
  } result_t;

endpackage

// ----- rtl/core/csvtok_parse.sv -----
// per-byte parse mode machine with line and column counters
`timescale 1ns / 1ps

module csvtok_parse #(
  parameter int unsigned LINE_BITS   = csvtok_pkg::LineBitsDefault,
  parameter int unsigned COLUMN_BITS = csvtok_pkg::ColumnBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [csvtok_pkg::ByteW-1:0] byte_i,
  input  logic [csvtok_pkg::ByteW-1:0] delim_i,
  output logic                         produce_o,
  output csvtok_pkg::result_t          result_o
);

  csvtok_pkg::mode_e mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [COLUMN_BITS-1:0] col_cur;
  logic is_nl, is_quote, is_delim;
  logic line_clamp, col_clamp;

  assign is_nl    = (byte_i == csvtok_pkg::NewlineByte);
  assign is_quote = (byte_i == csvtok_pkg::QuoteByte);
  assign is_delim = (byte_i == delim_i);

  assign col_cur = (col_q == {COLUMN_BITS{1'b1}}) ? col_q : col_q + 1'b1;

  // clamp to the fixed output widths
  assign line_clamp = (65'(line_q) > 65'({csvtok_pkg::LineOutW{1'b1}}));
  assign col_clamp  = (33'(col_cur) > 33'({csvtok_pkg::ColOutW{1'b1}}));

  always_comb begin
    mode_d                   = mode_q;
    produce_o                = 1'b1;
    result_o.kind            = csvtok_pkg::KIND_DATA;
    result_o.data_byte       = byte_i;
    result_o.stray_error     = 1'b0;
    result_o.line_number     = line_clamp ? {csvtok_pkg::LineOutW{1'b1}}
                                          : csvtok_pkg::LineOutW'(line_q);
    result_o.column_number   = col_clamp ? {csvtok_pkg::ColOutW{1'b1}}
                                         : csvtok_pkg::ColOutW'(col_cur);
    case (mode_q)
      csvtok_pkg::MODE_START, csvtok_pkg::MODE_PLAIN: begin
        if (mode_q == csvtok_pkg::MODE_START && is_quote) begin
          mode_d    = csvtok_pkg::MODE_QUOTED;
          produce_o = 1'b0;
        end else if (is_nl) begin
          result_o.kind      = csvtok_pkg::KIND_LINE_END;
          result_o.data_byte = '0;
          mode_d             = csvtok_pkg::MODE_START;
        end else if (is_delim) begin
          result_o.kind      = csvtok_pkg::KIND_FIELD_END;
          result_o.data_byte = '0;
          mode_d             = csvtok_pkg::MODE_START;
        end else begin
          mode_d = csvtok_pkg::MODE_PLAIN;
        end
      end
      csvtok_pkg::MODE_QUOTED: begin
        if (is_quote) begin
          mode_d    = csvtok_pkg::MODE_QUOTE_SEEN;
          produce_o = 1'b0;
        end
      end
      csvtok_pkg::MODE_QUOTE_SEEN: begin
        if (is_quote) begin
          // doubled quote
          result_o.data_byte = csvtok_pkg::QuoteByte;
          mode_d             = csvtok_pkg::MODE_QUOTED;
        end else if (is_nl) begin
          result_o.kind      = csvtok_pkg::KIND_LINE_END;
          result_o.data_byte = '0;
          mode_d             = csvtok_pkg::MODE_START;
        end else if (is_delim) begin
          result_o.kind      = csvtok_pkg::KIND_FIELD_END;
          result_o.data_byte = '0;
          mode_d             = csvtok_pkg::MODE_START;
        end else begin
          // stray byte after closing quote
          result_o.stray_error = 1'b1;
          mode_d               = csvtok_pkg::MODE_QUOTED;
        end
      end
      default: begin
        mode_d    = csvtok_pkg::MODE_START;
        produce_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (is_nl) begin
      line_d = (line_q == {LINE_BITS{1'b1}}) ? line_q : line_q + 1'b1;
      col_d  = '0;
    end else begin
      line_d = line_q;
      col_d  = col_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= csvtok_pkg::MODE_START;
      line_q <= '0;
      col_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

endmodule

// ----- rtl/core/csv_field_tokenizer_core.sv -----
// top level of the csv field tokenizer: config register, parser and output skid stage
`timescale 1ns / 1ps

// Splits a CSV byte stream into field content bytes, field ends and line ends,
// one input beat per clock cycle while s_axis_tready_o is high. The parse mode and the
// line and column counters update in the same cycle a byte is accepted, so back-to-back
// bytes run at full rate; each result lands in an output register backed by one skid entry,
// and s_axis_tready_o drops only when both hold unaccepted results. Opening and
// closing quotes produce no output beat. Write the delimiter only while idle.
module csv_field_tokenizer_core #(
  parameter int unsigned LINE_BITS   = csvtok_pkg::LineBitsDefault,
  parameter int unsigned COLUMN_BITS = csvtok_pkg::ColumnBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csvtok_pkg::ByteW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [csvtok_pkg::ByteW-1:0]  s_axis_tdata_i,   // byte_value
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [csvtok_pkg::TdataW-1:0] m_axis_tdata_o,   // data_byte, line_number, column_number
  output logic [csvtok_pkg::TuserW-1:0] m_axis_tuser_o    // kind, stray_error
);

  logic [csvtok_pkg::ByteW-1:0] delim_q;
  logic accept, produce, push, pop;
  csvtok_pkg::result_t res;
  csvtok_pkg::result_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;

  assign s_axis_tready_o = ~skid_valid_q;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign push            = accept & produce;
  assign pop             = out_valid_q & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= csvtok_pkg::DelimDefault;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  csvtok_parse #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (s_axis_tdata_i),
    .delim_i   (delim_q),
    .produce_o (produce),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !pop) begin
      skid_valid_q <= push;
    end else begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !pop) begin
      if (push) begin
        skid_q <= res;
      end
    end else if (push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.column_number, out_q.line_number, out_q.data_byte};
  assign m_axis_tuser_o  = {out_q.stray_error, out_q.kind};

endmodule

// ----- rtl/core/csvtok_checker.sv -----
// port-level checks for the csv field tokenizer, bound to the top level
`timescale 1ns / 1ps

module csvtok_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [csvtok_pkg::TdataW-1:0] m_axis_tdata_o,
  input logic [csvtok_pkg::TuserW-1:0] m_axis_tuser_o
);

  // input stalls only behind a held output beat
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no output beat pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output beat changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[1:0] == csvtok_pkg::KIND_DATA ||
                         m_axis_tuser_o[1:0] == csvtok_pkg::KIND_FIELD_END ||
                         m_axis_tuser_o[1:0] == csvtok_pkg::KIND_LINE_END))
    else $error("illegal result kind");

  a_end_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] != csvtok_pkg::KIND_DATA |->
      m_axis_tdata_o[7:0] == '0 && !m_axis_tuser_o[2])
    else $error("field or line end carries data or stray flag");

endmodule

bind csv_field_tokenizer_core csvtok_checker u_csvtok_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
